@@ rtl/cbiou_pkg.sv @@
`timescale 1ns / 1ps

package cbiou_pkg;

    localparam int MAX_DIM      = 4096;
    localparam int MAX_CLUSTERS = 256;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int CL_W   = 8;
    localparam int IDX_W  = 24;
    localparam int CFG_W  = 13;
    localparam int DET_W  = 12;
    localparam int THR_W  = 9;
    localparam int FRAC_W = 8;
    localparam int OV_W   = 24;
    localparam int UN_W   = 25;
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    localparam int DIV_STEPS = IDX_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DET_LEFT     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DET_TOP      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DET_WIDTH    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DET_HEIGHT   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_IOU_THRESH   = 3'd6;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quo;
        logic [CFG_W-1:0] rem;
    } div_res_t;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [IDX_W-1:0] v);
        if (v > IDX_W'(MAX_DIM - 1)) begin
            return DIM_W'(MAX_DIM - 1);
        end
        return v[DIM_W-1:0];
    endfunction

endpackage

@@ rtl/cbiou_div.sv @@
`timescale 1ns / 1ps

module cbiou_div
    import cbiou_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output div_res_t         res
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0]     acc_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     dvs_reg;

    logic [CFG_W:0] r1, r1s, r2, r2s;
    logic           q1, q0;

    // two restoring steps per cycle
    always_comb begin
        r1  = {rem_reg, acc_reg[IDX_W-1]};
        q1  = (r1 >= {1'b0, dvs_reg});
        r1s = q1 ? (r1 - {1'b0, dvs_reg}) : r1;
        r2  = {r1s[CFG_W-1:0], acc_reg[IDX_W-2]};
        q0  = (r2 >= {1'b0, dvs_reg});
        r2s = q0 ? (r2 - {1'b0, dvs_reg}) : r2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                acc_reg <= {acc_reg[IDX_W-3:0], q1, q0};
                rem_reg <= r2s[CFG_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.quo  = acc_reg;
    assign res.rem  = rem_reg;

endmodule

@@ rtl/cbiou_mul.sv @@
`timescale 1ns / 1ps

module cbiou_mul
    import cbiou_pkg::*;
(
    input  logic              aclk,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/cluster_box_iou_select_top.sv @@
`timescale 1ns / 1ps
// Point without cluster end: s_tready drops at accept and returns once the
// division ends, so one point is taken at a time; the 2-bit-per-cycle divider
// (12 steps) sets this. A cluster or set end adds scoring on the one shared
// 25x25 multiplier; a set end then adds the threshold, found and emit states.
// m_tvalid is set from ST_EMIT, later while the previous result waits on m_tready.
// Reset (synchronous, aresetn low) restores register defaults and clears the set.

module cluster_box_iou_select_top
    import cbiou_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,  // point_index[23:0]
    input  logic                  s_tuser,  // last_of_cluster
    input  logic                  s_tlast,  // last_of_set

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,  // chosen_cluster[7:0], best_overlap_area[31:8],
                                            // best_union_area[56:32], zero[63:57]
    output logic                  m_tuser   // found
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_GEOM,
        ST_MUL_OV,
        ST_MUL_CA,
        ST_MUL_DA,
        ST_UNION,
        ST_MUL_L,
        ST_MUL_R,
        ST_CMP,
        ST_MUL_F,
        ST_FOUND,
        ST_EMIT
    } state_t;

    // configuration
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [DET_W-1:0] det_left_reg;
    logic [DET_W-1:0] det_top_reg;
    logic [DET_W-1:0] det_width_reg;
    logic [DET_W-1:0] det_height_reg;
    logic [THR_W-1:0] iou_thresh_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= CFG_W'(640);
            image_height_reg <= CFG_W'(480);
            det_left_reg     <= '0;
            det_top_reg      <= '0;
            det_width_reg    <= '0;
            det_height_reg   <= '0;
            iou_thresh_reg   <= THR_W'(205);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[CFG_W-1:0];
                REG_DET_LEFT:     det_left_reg     <= pwdata[DET_W-1:0];
                REG_DET_TOP:      det_top_reg      <= pwdata[DET_W-1:0];
                REG_DET_WIDTH:    det_width_reg    <= pwdata[DET_W-1:0];
                REG_DET_HEIGHT:   det_height_reg   <= pwdata[DET_W-1:0];
                REG_IOU_THRESH:   iou_thresh_reg   <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            REG_DET_LEFT:     prdata = APB_DATA_W'(det_left_reg);
            REG_DET_TOP:      prdata = APB_DATA_W'(det_top_reg);
            REG_DET_WIDTH:    prdata = APB_DATA_W'(det_width_reg);
            REG_DET_HEIGHT:   prdata = APB_DATA_W'(det_height_reg);
            REG_IOU_THRESH:   prdata = APB_DATA_W'(iou_thresh_reg);
            default:          prdata = '0;
        endcase
    end

    // datapath state
    state_t            state_reg;
    logic              end_cl_reg;
    logic              end_set_reg;
    logic              box_valid_reg;
    logic [DIM_W-1:0]  min_col_reg, max_col_reg, min_row_reg, max_row_reg;
    logic [DIM_W-1:0]  ow_reg, oh_reg, cw_reg, ch_reg;
    logic [OV_W-1:0]   ov_reg, ca_reg;
    logic [UN_W-1:0]   un_reg;
    logic [PROD_W-1:0] lhs_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [OV_W-1:0]   best_ov_reg;
    logic [UN_W-1:0]   best_un_reg;
    logic [CL_W-1:0]   best_cl_reg;
    logic              found_reg;
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;
    logic              m_tuser_reg;

    logic              in_acc;
    logic [CFG_W-1:0]  divisor;
    div_res_t          div_res;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [DIM_W-1:0]  row, col;
    logic [DIM_W:0]    dx1, dy1;
    logic [DIM_W-1:0]  ox0, oy0, ox1, oy1;
    logic              out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign divisor  = (image_width_reg == '0) ? CFG_W'(1) : image_width_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    cbiou_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_acc),
        .dividend (s_tdata[IDX_W-1:0]),
        .divisor  (divisor),
        .res      (div_res)
    );

    cbiou_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign row = sat_dim(div_res.quo);
    assign col = sat_dim(IDX_W'(div_res.rem));

    always_comb begin
        dx1 = {1'b0, det_left_reg} + {1'b0, det_width_reg};
        dy1 = {1'b0, det_top_reg} + {1'b0, det_height_reg};
        ox0 = (min_col_reg > det_left_reg) ? min_col_reg : det_left_reg;
        oy0 = (min_row_reg > det_top_reg) ? min_row_reg : det_top_reg;
        ox1 = ({1'b0, max_col_reg} < dx1) ? max_col_reg : dx1[DIM_W-1:0];
        oy1 = ({1'b0, max_row_reg} < dy1) ? max_row_reg : dy1[DIM_W-1:0];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_OV: begin
                mul_a = MUL_W'(ow_reg);
                mul_b = MUL_W'(oh_reg);
            end
            ST_MUL_CA: begin
                mul_a = MUL_W'(cw_reg);
                mul_b = MUL_W'(ch_reg);
            end
            ST_MUL_DA: begin
                mul_a = MUL_W'(det_width_reg);
                mul_b = MUL_W'(det_height_reg);
            end
            ST_MUL_L: begin
                mul_a = MUL_W'(ov_reg);
                mul_b = best_un_reg;
            end
            ST_MUL_R: begin
                mul_a = MUL_W'(best_ov_reg);
                mul_b = un_reg;
            end
            ST_MUL_F: begin
                mul_a = MUL_W'(iou_thresh_reg);
                mul_b = best_un_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            box_valid_reg <= 1'b0;
            count_reg     <= '0;
            best_ov_reg   <= '0;
            best_un_reg   <= UN_W'(1);
            best_cl_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (state_reg == ST_EMIT) begin
                if (out_free) begin
                    m_tvalid_reg <= 1'b1;
                end
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        end_cl_reg  <= s_tuser;
                        end_set_reg <= s_tlast;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        box_valid_reg <= 1'b1;
                        if (!box_valid_reg || col < min_col_reg) min_col_reg <= col;
                        if (!box_valid_reg || col > max_col_reg) max_col_reg <= col;
                        if (!box_valid_reg || row < min_row_reg) min_row_reg <= row;
                        if (!box_valid_reg || row > max_row_reg) max_row_reg <= row;
                        state_reg <= (end_cl_reg || end_set_reg) ? ST_GEOM : ST_IDLE;
                    end
                end
                ST_GEOM: begin
                    ow_reg    <= (ox1 > ox0) ? (ox1 - ox0) : '0;
                    oh_reg    <= (oy1 > oy0) ? (oy1 - oy0) : '0;
                    cw_reg    <= max_col_reg - min_col_reg;
                    ch_reg    <= max_row_reg - min_row_reg;
                    state_reg <= ST_MUL_OV;
                end
                ST_MUL_OV: begin
                    state_reg <= ST_MUL_CA;
                end
                ST_MUL_CA: begin
                    ov_reg    <= prod[OV_W-1:0];
                    state_reg <= ST_MUL_DA;
                end
                ST_MUL_DA: begin
                    ca_reg    <= prod[OV_W-1:0];
                    state_reg <= ST_UNION;
                end
                ST_UNION: begin
                    un_reg    <= UN_W'(ca_reg) + UN_W'(prod[OV_W-1:0]) - UN_W'(ov_reg);
                    state_reg <= ST_MUL_L;
                end
                ST_MUL_L: begin
                    state_reg <= ST_MUL_R;
                end
                ST_MUL_R: begin
                    lhs_reg   <= prod;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (count_reg < CNT_W'(MAX_CLUSTERS)) begin
                        if (un_reg != '0 && lhs_reg > prod) begin
                            best_ov_reg <= ov_reg;
                            best_un_reg <= un_reg;
                            best_cl_reg <= count_reg[CL_W-1:0];
                        end
                        count_reg <= count_reg + 1'b1;
                    end
                    box_valid_reg <= 1'b0;
                    state_reg     <= end_set_reg ? ST_MUL_F : ST_IDLE;
                end
                ST_MUL_F: begin
                    state_reg <= ST_FOUND;
                end
                ST_FOUND: begin
                    found_reg <= (PROD_W'({best_ov_reg, {FRAC_W{1'b0}}}) >= prod);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tuser_reg  <= found_reg;
                        m_tdata_reg  <= {7'b0, best_un_reg, best_ov_reg,
                                         found_reg ? best_cl_reg : {CL_W{1'b0}}};
                        count_reg    <= '0;
                        best_ov_reg  <= '0;
                        best_un_reg  <= UN_W'(1);
                        best_cl_reg  <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ rtl/cbiou_checker.sv @@
`timescale 1ns / 1ps

module cbiou_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_no_match_cluster: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("cluster index reported without a match");

    a_union_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[56:32] != 25'd0 && m_tdata[63:57] == 7'd0)
        else $error("bad union area or padding");

endmodule

bind cluster_box_iou_select_top cbiou_checker u_cbiou_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
